>>> rtl/tmaf_pkg.sv
// ----------------------------------------------------------------------------
// tmaf_pkg
// shared constants, widths and controller/datapath types for the trimmed
// mean adc filter
// ----------------------------------------------------------------------------
package tmaf_pkg;

  localparam int CHANNELS  = 16;
  localparam int WINDOW    = 8;
  localparam int TRIM_DROP = 2;

  localparam int CHAN_W   = 4;
  localparam int SAMPLE_W = 12;
  localparam int TDATA_W  = ((CHAN_W + SAMPLE_W + 7) / 8) * 8;

  localparam int CH_IW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WIN_W    = $clog2(WINDOW);
  localparam int ADDR_W   = CH_IW + WIN_W;
  localparam int RAM_DEPTH = CHANNELS * (2 ** WIN_W);

  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
  localparam int DIVISOR  = WINDOW - TRIM_DROP;
  localparam int RECIP_SH = SUM_W + $clog2(DIVISOR) + 1;
  localparam int RECIP_W  = RECIP_SH - $clog2(DIVISOR) + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;

  localparam logic [RECIP_W-1:0]  RECIP      = RECIP_W'((2 ** RECIP_SH + DIVISOR - 1) / DIVISOR);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_LAST,
    S_MUL,
    S_DONE
  } tmaf_state_t;

  typedef struct packed {
    logic load;
    logic write;
    logic rd_start;
    logic rd_issue;
    logic mul;
    logic out_load;
  } tmaf_cmd_t;

  typedef struct packed {
    logic ch_ok;
    logic rd_last;
    logic out_free;
  } tmaf_sts_t;

endpackage

>>> rtl/trimmed_mean_adc_filter_top.sv
// ----------------------------------------------------------------------------
// trimmed_mean_adc_filter_top
// per-channel 8-sample window, drops one max and one min, floor mean of rest
//
//   channel | direction | tdata fields (low bit up)
//   in_     | slave     | channel[3:0], sample[15:4]
//   out_    | master    | out_channel[3:0], filtered[15:4]
//
// a valid channel's item steps through accept, ring write, 8 window reads
// through the one read port of the window ram, read drain, reciprocal
// multiply and hand-off; one beyond range skips from the write step to
// hand-off. the window ram read sweep sets the rate.
// synchronous active-low reset clears pointers and wrap flags; the ram itself
// is not swept. a stalled output holds its item; the next item is accepted
// meanwhile and waits in its final step until the output register frees.
// ----------------------------------------------------------------------------
module trimmed_mean_adc_filter_top
  import tmaf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // channel, sample
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata   // out_channel, filtered
);

  tmaf_cmd_t           cmd;
  tmaf_sts_t           sts;
  logic [CHAN_W-1:0]   out_channel;
  logic [SAMPLE_W-1:0] out_filtered;

  tmaf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tmaf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_channel   (in_tdata[CHAN_W-1:0]),
    .in_sample    (in_tdata[CHAN_W +: SAMPLE_W]),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_channel  (out_channel),
    .out_filtered (out_filtered)
  );

  assign out_tdata = TDATA_W'({out_filtered, out_channel});

endmodule

>>> rtl/tmaf_ram.sv
// ----------------------------------------------------------------------------
// tmaf_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tmaf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/tmaf_ctrl.sv
// ----------------------------------------------------------------------------
// tmaf_ctrl
// sequencer: accept, ring write, window read sweep, divide, hand off result
// ----------------------------------------------------------------------------
module tmaf_ctrl
  import tmaf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  tmaf_sts_t sts,
  output tmaf_cmd_t cmd
);

  tmaf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        // out-of-range channel skips straight to a zero result
        state_nxt = sts.ch_ok ? S_READ : S_DONE;
      end
      S_READ: begin
        if (sts.rd_last) state_nxt = S_LAST;
      end
      S_LAST: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_WRITE: begin
        cmd.write    = 1'b1;
        cmd.rd_start = 1'b1;
      end
      S_READ: cmd.rd_issue = 1'b1;
      S_LAST: ;
      S_MUL:  cmd.mul = 1'b1;
      S_DONE: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/tmaf_dp.sv
// ----------------------------------------------------------------------------
// tmaf_dp
// datapath: per-channel ring pointers, window ram, running sum/max/min,
// reciprocal divide and output register
// ----------------------------------------------------------------------------
module tmaf_dp
  import tmaf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CHAN_W-1:0]   in_channel,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  tmaf_cmd_t           cmd,
  output tmaf_sts_t           sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAN_W-1:0]   out_channel,
  output logic [SAMPLE_W-1:0] out_filtered
);

  logic [CHAN_W-1:0]   ch_r;
  logic [SAMPLE_W-1:0] smp_r;
  logic                ok_r;

  logic [WIN_W-1:0]    wp_r [CHANNELS];
  logic [CHANNELS-1:0] full_r;
  logic [WIN_W-1:0]    k_r;

  logic                rv_r;
  logic                rok_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] hi_r;
  logic [SAMPLE_W-1:0] lo_r;
  logic [PROD_W-1:0]   prod_r;

  logic                out_valid_r;
  logic [CHAN_W-1:0]   out_ch_r;
  logic [SAMPLE_W-1:0] out_filt_r;

  logic [CH_IW-1:0]    ch_idx;
  logic [WIN_W-1:0]    wp_cur;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr;
  logic [SAMPLE_W-1:0] rdata;
  logic [SAMPLE_W-1:0] v;
  logic [SUM_W-1:0]    trimmed;

  assign ch_idx = ch_r[CH_IW-1:0];
  assign wp_cur = wp_r[ch_idx];
  assign we     = cmd.write && ok_r;
  assign waddr  = {ch_idx, wp_cur};
  assign raddr  = {ch_idx, k_r};

  tmaf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (smp_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r  <= in_channel;
      smp_r <= in_sample;
      ok_r  <= (32'(in_channel) < CHANNELS);
    end
  end

  // ring pointers and wrap flags; unwritten ram entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wp_r[i] <= '0;
      end
      full_r <= '0;
    end else if (we) begin
      if (wp_cur == WIN_W'(WINDOW - 1)) begin
        wp_r[ch_idx]   <= '0;
        full_r[ch_idx] <= 1'b1;
      end else begin
        wp_r[ch_idx] <= wp_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else begin
      rv_r <= cmd.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      k_r <= '0;
    end else if (cmd.rd_issue) begin
      k_r <= k_r + 1'b1;
    end
    rok_r <= full_r[ch_idx] || (k_r < wp_cur);
  end

  assign v = rok_r ? rdata : '0;

  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      sum_r <= '0;
      hi_r  <= '0;
      lo_r  <= SAMPLE_MAX;
    end else if (rv_r) begin
      sum_r <= sum_r + SUM_W'(v);
      if (v > hi_r) hi_r <= v;
      if (v < lo_r) lo_r <= v;
    end
  end

  assign trimmed = sum_r - SUM_W'(hi_r) - SUM_W'(lo_r);

  // divide by the constant via reciprocal multiply
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(trimmed) * PROD_W'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch_r   <= ch_r;
      out_filt_r <= ok_r ? prod_r[RECIP_SH +: SAMPLE_W] : '0;
    end
  end

  assign sts.ch_ok    = ok_r;
  assign sts.rd_last  = (k_r == WIN_W'(WINDOW - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_channel  = out_ch_r;
  assign out_filtered = out_filt_r;

endmodule
